// ----- rtl/sfcv_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and tables for the sector footer checksum verifier
// used by sfcv_sum_core, the top level and the checker; no dependencies

package sfcv_pkg;

    localparam int SECTOR_BYTES   = 4096;
    localparam int OFF_W          = $clog2(SECTOR_BYTES);
    localparam int POS_W          = 6;
    localparam int ID_COUNT       = 14;
    localparam int SLOT_COUNT     = 4;
    localparam int SLOT_W         = $clog2(SLOT_COUNT);
    localparam int ID_IDX_W       = $clog2(ID_COUNT);
    localparam int IN_TDATA_W     = 16;
    localparam int OUT_TDATA_W    = 40;

    localparam int DEF_ID_OFFSET        = 4084;
    localparam int DEF_CHECKSUM_OFFSET  = 4086;
    localparam int DEF_SIGNATURE_OFFSET = 4088;
    localparam int DEF_SECTOR_TOTAL     = 32;

    localparam logic [31:0] SIGNATURE_RESET = 32'h0801_2025;

    typedef enum logic [2:0] {
        STATUS_VALID   = 3'd0,
        STATUS_BAD_POS = 3'd1,
        STATUS_BAD_SIG = 3'd2,
        STATUS_UNK_ID  = 3'd3,
        STATUS_MISMATCH = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0]      id;
        logic [15:0]      checksum;
        logic [31:0]      signature;
        logic [POS_W-1:0] position;
    } footer_t;

    typedef logic [SLOT_COUNT-1:0][31:0] slot_sums_t;

    // offset of the last byte of each data length
    function automatic logic [OFF_W-1:0] slot_last_off(input logic [SLOT_W-1:0] k);
        logic [OFF_W-1:0] r;
        case (k)
            2'd0:    r = OFF_W'(2000 - 1);
            2'd1:    r = OFF_W'(3848 - 1);
            2'd2:    r = OFF_W'(3884 - 1);
            default: r = OFF_W'(3968 - 1);
        endcase
        return r;
    endfunction

    // data length slot used by each footer id
    function automatic logic [SLOT_W-1:0] id_slot(input logic [ID_IDX_W-1:0] id);
        logic [SLOT_W-1:0] r;
        case (id)
            4'd0:    r = 2'd2;
            4'd4:    r = 2'd1;
            4'd13:   r = 2'd0;
            default: r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] fold16(input logic [31:0] s);
        return s[31:16] + s[15:0];
    endfunction

endpackage

// ----- rtl/sfcv_sum_core.sv -----
`timescale 1ns / 1ps
// per-byte state: offset counter, word assembly, running sum, length snapshots
// and footer field captures; depends on sfcv_pkg

module sfcv_sum_core #(
    parameter int ID_OFFSET        = sfcv_pkg::DEF_ID_OFFSET,
    parameter int CHECKSUM_OFFSET  = sfcv_pkg::DEF_CHECKSUM_OFFSET,
    parameter int SIGNATURE_OFFSET = sfcv_pkg::DEF_SIGNATURE_OFFSET
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic [7:0]                 data_byte,
    input  logic [sfcv_pkg::POS_W-1:0] sector_position,
    output logic                       last_byte,
    output sfcv_pkg::footer_t          footer,
    output sfcv_pkg::slot_sums_t       length_sums
);

    localparam int OFF_W = sfcv_pkg::OFF_W;
    localparam logic [OFF_W-1:0] ID_LO  = OFF_W'(ID_OFFSET);
    localparam logic [OFF_W-1:0] ID_HI  = OFF_W'(ID_OFFSET + 1);
    localparam logic [OFF_W-1:0] CHK_LO = OFF_W'(CHECKSUM_OFFSET);
    localparam logic [OFF_W-1:0] CHK_HI = OFF_W'(CHECKSUM_OFFSET + 1);
    localparam logic [OFF_W-1:0] SIG_0  = OFF_W'(SIGNATURE_OFFSET);
    localparam logic [OFF_W-1:0] LAST   = OFF_W'(sfcv_pkg::SECTOR_BYTES - 1);

    logic [OFF_W-1:0]     byte_offset_reg, byte_offset_next;
    logic [23:0]          word_bytes_reg, word_bytes_next;
    logic [31:0]          running_sum_reg, running_sum_next;
    sfcv_pkg::slot_sums_t length_sums_reg, length_sums_next;
    sfcv_pkg::footer_t    footer_reg, footer_next;

    logic [31:0] sum_base;

    assign last_byte   = (byte_offset_reg == LAST);
    assign footer      = footer_reg;
    assign length_sums = length_sums_reg;

    always_comb
    begin
        byte_offset_next = byte_offset_reg;
        word_bytes_next  = word_bytes_reg;
        running_sum_next = running_sum_reg;
        length_sums_next = length_sums_reg;
        footer_next      = footer_reg;
        sum_base         = (byte_offset_reg == '0) ? 32'd0 : running_sum_reg;

        if (step)
        begin
            if (byte_offset_reg == '0)
            begin
                footer_next.position = sector_position;
                running_sum_next     = 32'd0;
                length_sums_next     = '0;
            end

            case (byte_offset_reg[1:0])
                2'd0:    word_bytes_next = {16'd0, data_byte};
                2'd1:    word_bytes_next = {8'd0, data_byte, word_bytes_reg[7:0]};
                2'd2:    word_bytes_next = {data_byte, word_bytes_reg[15:0]};
                default:
                begin
                    running_sum_next = sum_base + {data_byte, word_bytes_reg};
                    word_bytes_next  = 24'd0;
                    for (int k = 0; k < sfcv_pkg::SLOT_COUNT; k++)
                    begin
                        if (byte_offset_reg == sfcv_pkg::slot_last_off(sfcv_pkg::SLOT_W'(k)))
                        begin
                            length_sums_next[k] = sum_base + {data_byte, word_bytes_reg};
                        end
                    end
                end
            endcase

            if (byte_offset_reg == ID_LO)
            begin
                footer_next.id[7:0] = data_byte;
            end
            if (byte_offset_reg == ID_HI)
            begin
                footer_next.id[15:8] = data_byte;
            end
            if (byte_offset_reg == CHK_LO)
            begin
                footer_next.checksum[7:0] = data_byte;
            end
            if (byte_offset_reg == CHK_HI)
            begin
                footer_next.checksum[15:8] = data_byte;
            end
            for (int k = 0; k < 4; k++)
            begin
                if (byte_offset_reg == SIG_0 + OFF_W'(k))
                begin
                    footer_next.signature[8*k +: 8] = data_byte;
                end
            end

            byte_offset_next = byte_offset_reg + OFF_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg <= '0;
            word_bytes_reg  <= '0;
            running_sum_reg <= '0;
            length_sums_reg <= '0;
            footer_reg      <= '0;
        end
        else
        begin
            byte_offset_reg <= byte_offset_next;
            word_bytes_reg  <= word_bytes_next;
            running_sum_reg <= running_sum_next;
            length_sums_reg <= length_sums_next;
            footer_reg      <= footer_next;
        end
    end

endmodule

// ----- rtl/sector_footer_checksum_verifier_core.sv -----
`timescale 1ns / 1ps
// top level of the sector footer checksum verifier: input register, per-byte
// state core and result register; depends on sfcv_pkg and sfcv_sum_core
//
// usage:
//   s_axis carries one sector byte per word, offset counted from zero; the
//   sector position is sampled with the first byte of each sector.
//   after the last byte (offset 4095) m_axis carries one result word:
//   status, folded checksum for the id's data length, known flag and id.
//   cfg_wr_en/cfg_wr_data load the expected footer signature; write it only
//   while no sector is in progress.
//   throughput: one byte per cycle unless stalled; the accumulator does one
//   32-bit add per word so the byte path never waits on it.
//   result path: the last byte passes the input register, the state update
//   and the result register before the result word shows on m_axis.
//   stall: the result register holds while m_axis_tready is low; bytes keep
//   flowing unless a second result is due while the first is still held,
//   then s_axis_tready drops until the held word is taken.
//   reset: clears the offset, sums, footer captures and pipeline valids and
//   loads the signature register with its default 0x08012025.

module sector_footer_checksum_verifier_core #(
    parameter int ID_OFFSET        = sfcv_pkg::DEF_ID_OFFSET,
    parameter int CHECKSUM_OFFSET  = sfcv_pkg::DEF_CHECKSUM_OFFSET,
    parameter int SIGNATURE_OFFSET = sfcv_pkg::DEF_SIGNATURE_OFFSET,
    parameter int SECTOR_TOTAL     = sfcv_pkg::DEF_SECTOR_TOTAL
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // data_byte[7:0], sector_position[13:8], zero [15:14]
    input  logic [sfcv_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status[2:0], computed_checksum[18:3], checksum_known[19],
    // sector_id[35:20], zero [39:36]
    output logic [sfcv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                             cfg_wr_en,
    input  logic [31:0]                      cfg_wr_data
);

    localparam int POS_W = sfcv_pkg::POS_W;
    localparam logic [POS_W:0] POS_LIMIT = (POS_W+1)'(SECTOR_TOTAL);

    logic                 stall;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic [POS_W-1:0]     in_pos_reg;
    logic                 fin_reg;
    logic [31:0]          signature_reg;
    logic                 out_valid_reg;
    logic [sfcv_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                 last_byte;
    sfcv_pkg::footer_t    footer;
    sfcv_pkg::slot_sums_t length_sums;

    logic                 known;
    logic [15:0]          chk;
    sfcv_pkg::status_t    status;

    assign stall         = fin_reg && out_valid_reg && !m_axis_tready;
    assign s_axis_tready = !stall;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    sfcv_sum_core #(
        .ID_OFFSET       (ID_OFFSET),
        .CHECKSUM_OFFSET (CHECKSUM_OFFSET),
        .SIGNATURE_OFFSET(SIGNATURE_OFFSET)
    ) u_sum_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (in_valid_reg && !stall),
        .data_byte      (in_byte_reg),
        .sector_position(in_pos_reg),
        .last_byte      (last_byte),
        .footer         (footer),
        .length_sums    (length_sums)
    );

    always_comb
    begin
        known = (footer.id < 16'(sfcv_pkg::ID_COUNT));
        chk   = known ? sfcv_pkg::fold16(
                    length_sums[sfcv_pkg::id_slot(footer.id[sfcv_pkg::ID_IDX_W-1:0])])
                      : 16'd0;
        if ({1'b0, footer.position} >= POS_LIMIT)
        begin
            status = sfcv_pkg::STATUS_BAD_POS;
        end
        else if (footer.signature != signature_reg)
        begin
            status = sfcv_pkg::STATUS_BAD_SIG;
        end
        else if (!known)
        begin
            status = sfcv_pkg::STATUS_UNK_ID;
        end
        else if (chk != footer.checksum)
        begin
            status = sfcv_pkg::STATUS_MISMATCH;
        end
        else
        begin
            status = sfcv_pkg::STATUS_VALID;
        end
        out_data_next = {4'd0, footer.id, known, chk, status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            signature_reg <= sfcv_pkg::SIGNATURE_RESET;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                signature_reg <= cfg_wr_data;
            end
            if (!stall)
            begin
                in_valid_reg <= s_axis_tvalid;
                fin_reg      <= in_valid_reg && last_byte;
            end
            if (fin_reg && !stall)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && !stall)
        begin
            in_byte_reg <= s_axis_tdata[7:0];
            in_pos_reg  <= s_axis_tdata[8 +: POS_W];
        end
        if (fin_reg && !stall)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- rtl/sfcv_checker.sv -----
`timescale 1ns / 1ps
// port-level checks for the sector footer checksum verifier, bound to the top
// level; depends on sfcv_pkg

module sfcv_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [sfcv_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [2:0]  st;
    logic [15:0] chk;
    logic        known;

    assign st    = m_axis_tdata[2:0];
    assign chk   = m_axis_tdata[18:3];
    assign known = m_axis_tdata[19];

    // held result word stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // unknown id reports zero checksum
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !known |-> chk == 16'd0)
        else $error("unknown id with nonzero checksum");

    // valid or mismatch only for a known id
    a_known_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (st == sfcv_pkg::STATUS_VALID || st == sfcv_pkg::STATUS_MISMATCH)
        |-> known)
        else $error("checksum status for unknown id");

    // unknown id status only when id is unknown
    a_unknown_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && st == sfcv_pkg::STATUS_UNK_ID |-> !known)
        else $error("unknown id status with known id");

endmodule

bind sector_footer_checksum_verifier_core sfcv_checker u_sfcv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// ----- verif/sector_footer_checksum_verifier_core_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for sector_footer_checksum_verifier_core: streams whole sectors byte
// by byte and checks every result word against a byte-level model of the folded word sum
// depends on sfcv_pkg and the rtl top level

module sector_footer_checksum_verifier_core_test;

    localparam int ID_OFF        = sfcv_pkg::DEF_ID_OFFSET;
    localparam int CSUM_OFF      = sfcv_pkg::DEF_CHECKSUM_OFFSET;
    localparam int SIG_OFF       = sfcv_pkg::DEF_SIGNATURE_OFFSET;
    localparam int POS_LIMIT     = sfcv_pkg::DEF_SECTOR_TOTAL;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int POS_W         = sfcv_pkg::POS_W;
    localparam int SECTOR_BYTES  = sfcv_pkg::SECTOR_BYTES;
    localparam int SLOT_COUNT    = sfcv_pkg::SLOT_COUNT;
    localparam int ID_COUNT      = sfcv_pkg::ID_COUNT;

    // data length per slot, slot per footer id; entry zero in the low bits
    localparam logic [SLOT_COUNT-1:0][11:0] SLOT_LEN =
        {12'd3968, 12'd3884, 12'd3848, 12'd2000};
    localparam logic [ID_COUNT-1:0][1:0] SLOT_OF_ID =
        {2'd0, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd1, 2'd3, 2'd3, 2'd3, 2'd2};

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    typedef struct packed {
        sfcv_pkg::status_t status;
        logic [15:0]       checksum;
        logic              known;
        logic [15:0]       id;
    } verdict_t;

    logic                             clk;
    logic                             rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [sfcv_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [sfcv_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             cfg_wr_en;
    logic [31:0]                      cfg_wr_data;

    // model state
    logic [31:0]                  sig_model = sfcv_pkg::SIGNATURE_RESET;
    int unsigned                  at_off = 0;
    logic [23:0]                  partial_word = '0;
    logic [31:0]                  word_total = '0;
    logic [SLOT_COUNT-1:0][31:0]  slot_total = '0;
    logic [15:0]                  cap_id = '0;
    logic [15:0]                  cap_csum = '0;
    logic [31:0]                  cap_sig = '0;
    logic [POS_W-1:0]             cap_pos = '0;
    verdict_t                     awaited_verdicts[$];

    // stimulus state
    logic [7:0]       sector_img [SECTOR_BYTES];
    logic [13:0]      byte_backlog[$];
    logic [31:0]      cur_sig;
    int unsigned      send_gap = 0;
    int unsigned      recv_gap = 0;
    bit               in_taken = 0;
    bit               calm = 0;
    int unsigned      cycles = 0;
    int unsigned      verdict_errors = 0;

    sector_footer_checksum_verifier_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic absorb_byte(input logic [7:0] b, input logic [POS_W-1:0] pos);
        verdict_t    v;
        logic [31:0] chosen;
        if (at_off == 0)
        begin
            cap_pos = pos;
            word_total = '0;
            slot_total = '0;
        end
        case (at_off % 4)
            0: partial_word = {16'h0, b};
            1: partial_word[15:8] = b;
            2: partial_word[23:16] = b;
            default:
            begin
                word_total = word_total + {b, partial_word};
                partial_word = '0;
                for (int k = 0; k < SLOT_COUNT; k++)
                    if (at_off + 1 == SLOT_LEN[k])
                        slot_total[k] = word_total;
            end
        endcase
        // footer fields may overlap, each capture stands alone
        if (at_off == ID_OFF)
            cap_id[7:0] = b;
        if (at_off == ID_OFF + 1)
            cap_id[15:8] = b;
        if (at_off == CSUM_OFF)
            cap_csum[7:0] = b;
        if (at_off == CSUM_OFF + 1)
            cap_csum[15:8] = b;
        if (at_off >= SIG_OFF && at_off < SIG_OFF + 4)
            cap_sig[8 * (at_off - SIG_OFF) +: 8] = b;
        if (at_off != SECTOR_BYTES - 1)
            at_off = at_off + 1;
        else
        begin
            at_off = 0;
            v.id = cap_id;
            v.known = cap_id < ID_COUNT;
            v.checksum = '0;
            if (v.known)
            begin
                chosen = slot_total[SLOT_OF_ID[cap_id[3:0]]];
                v.checksum = chosen[31:16] + chosen[15:0];
            end
            if (cap_pos >= POS_LIMIT)
                v.status = sfcv_pkg::STATUS_BAD_POS;
            else if (cap_sig != sig_model)
                v.status = sfcv_pkg::STATUS_BAD_SIG;
            else if (!v.known)
                v.status = sfcv_pkg::STATUS_UNK_ID;
            else if (v.checksum != cap_csum)
                v.status = sfcv_pkg::STATUS_MISMATCH;
            else
                v.status = sfcv_pkg::STATUS_VALID;
            awaited_verdicts.push_back(v);
        end
    endtask

    task automatic queue_sector(input logic [POS_W-1:0] pos, input logic [15:0] id,
                                input fill_t fill, input bit spoil_sum, input logic [31:0] sig);
        logic [31:0] acc;
        logic [15:0] csum;
        for (int i = 0; i < SECTOR_BYTES; i++)
            sector_img[i] = (fill == FILL_ZERO) ? 8'h00 :
                            (fill == FILL_ONES) ? 8'hff : 8'($urandom);
        acc = '0;
        if (id < ID_COUNT)
            for (int i = 0; i < SLOT_LEN[SLOT_OF_ID[id[3:0]]]; i += 4)
                acc = acc + {sector_img[i + 3], sector_img[i + 2],
                             sector_img[i + 1], sector_img[i]};
        csum = acc[31:16] + acc[15:0];
        if (id >= ID_COUNT)
            csum = 16'($urandom);
        else if (spoil_sum)
            csum = csum ^ 16'($urandom_range(1, 65535));
        sector_img[ID_OFF]       = id[7:0];
        sector_img[ID_OFF + 1]   = id[15:8];
        sector_img[CSUM_OFF]     = csum[7:0];
        sector_img[CSUM_OFF + 1] = csum[15:8];
        for (int i = 0; i < 4; i++)
            sector_img[SIG_OFF + i] = sig[8 * i +: 8];
        // position only counts on the first byte, the rest carry noise
        for (int i = 0; i < SECTOR_BYTES; i++)
            byte_backlog.push_back({(i == 0) ? pos : POS_W'($urandom), sector_img[i]});
    endtask

    task automatic queue_random_sector();
        int unsigned      pick;
        int unsigned      shade;
        logic [POS_W-1:0] pos;
        logic [15:0]      id;
        logic [31:0]      sig;
        fill_t            fill;
        bit               spoil;
        pick = $urandom_range(0, 9);
        shade = $urandom_range(0, 7);
        pos = POS_W'($urandom_range(0, POS_LIMIT - 1));
        id = 16'($urandom_range(0, ID_COUNT - 1));
        sig = cur_sig;
        spoil = 1'b0;
        fill = FILL_RANDOM;
        if (shade == 0)
            fill = FILL_ZERO;
        else if (shade == 1)
            fill = FILL_ONES;
        // mostly well-formed sectors, the rest broken in one way
        if (pick == 6)
            spoil = 1'b1;
        else if (pick == 7)
            pos = POS_W'($urandom_range(POS_LIMIT, 63));
        else if (pick == 8)
        begin
            sig = $urandom;
            if (sig == cur_sig)
                sig = ~sig;
        end
        else if (pick == 9)
            id = 16'($urandom_range(ID_COUNT, 65535));
        queue_sector(pos, id, fill, spoil, sig);
    endtask

    task automatic settle();
        while (byte_backlog.size() != 0 || s_axis_tvalid || awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_signature(input logic [31:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_sig = value;
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (send_gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (byte_backlog.size() != 0)
            begin
                s_axis_tdata <= {2'b00, byte_backlog.pop_front()};
                s_axis_tvalid <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 6);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (recv_gap != 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap = recv_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0)
                    recv_gap = $urandom_range(1, 6);
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_t got;
        verdict_t want;
        if (rst_n)
        begin
            cycles = cycles + 1;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
            begin
                if (cfg_wr_en)
                    sig_model = cfg_wr_data;
                in_taken = s_axis_tvalid && s_axis_tready;
                if (in_taken)
                    absorb_byte(s_axis_tdata[7:0], s_axis_tdata[8 +: POS_W]);
                if (m_axis_tvalid && m_axis_tready)
                begin
                    got.status   = sfcv_pkg::status_t'(m_axis_tdata[2:0]);
                    got.checksum = m_axis_tdata[18:3];
                    got.known    = m_axis_tdata[19];
                    got.id       = m_axis_tdata[35:20];
                    if (awaited_verdicts.size() == 0)
                    begin
                        $error("result word with no sector pending: %h", m_axis_tdata);
                        verdict_errors = verdict_errors + 1;
                    end
                    else
                    begin
                        want = awaited_verdicts.pop_front();
                        if (got.status != want.status)
                        begin
                            $error("status expected %0d got %0d", want.status, got.status);
                            verdict_errors = verdict_errors + 1;
                        end
                        if (got.checksum != want.checksum)
                        begin
                            $error("computed_checksum expected %h got %h",
                                   want.checksum, got.checksum);
                            verdict_errors = verdict_errors + 1;
                        end
                        if (got.known != want.known)
                        begin
                            $error("checksum_known expected %0d got %0d",
                                   want.known, got.known);
                            verdict_errors = verdict_errors + 1;
                        end
                        if (got.id != want.id)
                        begin
                            $error("sector_id expected %h got %h", want.id, got.id);
                            verdict_errors = verdict_errors + 1;
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        cur_sig = sfcv_pkg::SIGNATURE_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // corner sectors under the reset signature
        queue_sector(6'd0, 16'd0, FILL_ZERO, 1'b0, cur_sig);
        queue_sector(6'd31, 16'd13, FILL_ONES, 1'b0, cur_sig);
        queue_sector(6'd32, 16'd4, FILL_RANDOM, 1'b0, cur_sig);
        queue_sector(6'd63, 16'hffff, FILL_RANDOM, 1'b0, cur_sig);
        queue_sector(6'd5, 16'd7, FILL_RANDOM, 1'b0, ~cur_sig);
        queue_sector(6'd1, 16'd14, FILL_RANDOM, 1'b0, cur_sig);
        queue_sector(6'd2, 16'd2, FILL_ONES, 1'b1, cur_sig);

        for (int p = 0; p < 4; p++)
        begin
            if (p != 0)
            begin
                settle();
                if (p == 1)
                    write_signature(32'h0000_0000);
                else if (p == 2)
                    write_signature(32'hffff_ffff);
                else
                    write_signature($urandom);
            end
            repeat (8) queue_random_sector();
        end
        calm = 1'b1;
        repeat (6) queue_random_sector();
        settle();

        repeat (12) @(posedge clk);
        if (verdict_errors == 0 && awaited_verdicts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
